### sv/nttoi_pkg.sv
// ----------------------------------------------------------------------------
// nttoi_pkg
// Shared types and helpers for the numeral text to 128-bit integer parser.
// ----------------------------------------------------------------------------
package nttoi_pkg;

    // accumulator width and its two 64-bit halves
    localparam int ACC_W  = 128;
    localparam int HALF_W = 64;

    // characters that matter to the parser
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_X_LO = 8'h78;
    localparam logic [7:0] CH_X_UP = 8'h58;
    localparam logic [7:0] CH_B_LO = 8'h62;
    localparam logic [7:0] CH_B_UP = 8'h42;
    localparam logic [7:0] CH_O_LO = 8'h6F;
    localparam logic [7:0] CH_O_UP = 8'h4F;

    // number base selected for the current literal
    typedef enum logic [1:0] {
        RADIX_2,
        RADIX_8,
        RADIX_10,
        RADIX_16
    } radix_t;

    // one classified character handed from the front to the back
    typedef struct packed {
        logic [3:0] digit;
        radix_t     radix;
        logic       bad;
        logic       last;
    } entry_t;

    // queue occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    // numeric value of a base, for the digit range check
    function automatic logic [4:0] radix_limit(radix_t r);
        logic [4:0] lim;
        case (r)
            RADIX_2:  lim = 5'd2;
            RADIX_8:  lim = 5'd8;
            RADIX_10: lim = 5'd10;
            RADIX_16: lim = 5'd16;
            default:  lim = 5'd10;
        endcase
        return lim;
    endfunction

endpackage

### sv/numeral_text_to_int128.sv
// ----------------------------------------------------------------------------
// numeral_text_to_int128
// Parses a numeral literal, one ascii character per beat, into 128 bits.
// ----------------------------------------------------------------------------
// Usage:
//   char channel: char_valid / char_stall carry char_code and is_last; a
//   literal is a run of beats closed by one with is_last set. A leading
//   "0x", "0b" or "0o" (either case) picks base 16, 2 or 8 when more
//   characters follow; otherwise the base is 10.
//   res channel: res_valid / res_stall carry low_half, high_half and
//   valid_res, one beat per literal; an illegal character gives valid_res
//   low and both halves zero. The value wraps modulo 2^128.
//   Throughput: one character per cycle while char_stall is low, set by
//   the shift-and-add update of the 128-bit accumulator in the back end.
//   The last character of a literal passes through the two-entry queue
//   and then the output register before its result beat shows up.
//   While res_stall holds, the result beat waits in its register; the
//   queue keeps taking characters until a second last character backs up,
//   then char_stall rises. Reset clears the queue, the base and the
//   accumulator; no clearing pass is needed.
// ----------------------------------------------------------------------------
module numeral_text_to_int128 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  char_code,
    input  logic        is_last,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [63:0] low_half,
    output logic [63:0] high_half,
    output logic        valid_res
);
    import nttoi_pkg::*;

    fifo_status_t q_status;
    entry_t       push_entry;
    entry_t       head;
    logic         push;
    logic         pop;

    // character classification and prefix tracking
    nttoi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_code  (char_code),
        .is_last    (is_last),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // decoupling queue
    nttoi_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // accumulator and result register
    nttoi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .low_half  (low_half),
        .high_half (high_half),
        .valid_res (valid_res)
    );

`ifndef ASSERT_OFF
    // queue never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("digit queue overflow");

    // back end never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("digit queue underflow");

    // an invalid literal reports zero halves
    a_zero_on_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !valid_res) |-> (low_half == '0 && high_half == '0))
        else $error("invalid literal with nonzero value");
`endif

endmodule

### sv/nttoi_front.sv
// ----------------------------------------------------------------------------
// nttoi_front
// Accepts characters, tracks the base prefix and classifies each character
// into a digit beat for the arithmetic back end.
// ----------------------------------------------------------------------------
module nttoi_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  logic [7:0]            char_code,
    input  logic                  is_last,
    input  nttoi_pkg::fifo_status_t q_status,
    output logic                  push,
    output nttoi_pkg::entry_t     push_entry
);
    import nttoi_pkg::*;

    radix_t     radix_reg, radix_next;
    logic [1:0] position_reg, position_next;
    logic       first_zero_reg, first_zero_next;

    logic       accept;
    logic       prefix_slot;
    logic       is_prefix;
    radix_t     prefix_radix;
    logic       is_digit;
    logic [3:0] digit_val;

    // a beat is taken whenever the queue has room
    assign char_stall = q_status.full;
    assign accept     = char_valid && !char_stall;

    // prefix letter only counts as second character after a zero, not last
    assign prefix_slot = (position_reg == 2'd1) && first_zero_reg && !is_last;

    always_comb
    begin
        is_prefix    = 1'b0;
        prefix_radix = radix_reg;
        if (prefix_slot)
        begin
            if (char_code == CH_X_LO || char_code == CH_X_UP)
            begin
                is_prefix    = 1'b1;
                prefix_radix = RADIX_16;
            end
            else if (char_code == CH_B_LO || char_code == CH_B_UP)
            begin
                is_prefix    = 1'b1;
                prefix_radix = RADIX_2;
            end
            else if (char_code == CH_O_LO || char_code == CH_O_UP)
            begin
                is_prefix    = 1'b1;
                prefix_radix = RADIX_8;
            end
        end
    end

    // ascii digit decode
    always_comb
    begin
        is_digit  = 1'b1;
        digit_val = 4'd0;
        case (char_code) inside
            [8'h30:8'h39]: digit_val = 4'(char_code - 8'h30);
            [8'h61:8'h66]: digit_val = 4'(char_code - 8'h61 + 8'd10);
            [8'h41:8'h46]: digit_val = 4'(char_code - 8'h41 + 8'd10);
            default:       is_digit  = 1'b0;
        endcase
    end

    // classified beat toward the back end; prefix letters add nothing
    assign push             = accept && !is_prefix;
    assign push_entry.digit = digit_val;
    assign push_entry.radix = radix_reg;
    assign push_entry.bad   = !is_digit || ({1'b0, digit_val} >= radix_limit(radix_reg));
    assign push_entry.last  = is_last;

    // literal state, back to reset after the last character
    always_comb
    begin
        radix_next      = radix_reg;
        position_next   = position_reg;
        first_zero_next = first_zero_reg;
        if (accept)
        begin
            if (is_last)
            begin
                radix_next      = RADIX_10;
                position_next   = 2'd0;
                first_zero_next = 1'b0;
            end
            else
            begin
                radix_next = prefix_radix;
                if (position_reg == 2'd0)
                begin
                    first_zero_next = (char_code == CH_ZERO);
                end
                if (position_reg != 2'd2)
                begin
                    position_next = position_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= RADIX_10;
            position_reg   <= 2'd0;
            first_zero_reg <= 1'b0;
        end
        else
        begin
            radix_reg      <= radix_next;
            position_reg   <= position_next;
            first_zero_reg <= first_zero_next;
        end
    end

endmodule

### sv/nttoi_fifo.sv
// ----------------------------------------------------------------------------
// nttoi_fifo
// Two-entry queue of classified digit beats between front and back end.
// ----------------------------------------------------------------------------
module nttoi_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  nttoi_pkg::entry_t       push_entry,
    input  logic                    pop,
    output nttoi_pkg::entry_t       head,
    output nttoi_pkg::fifo_status_t status
);
    import nttoi_pkg::*;

    entry_t     slots [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head         = slots[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### sv/nttoi_back.sv
// ----------------------------------------------------------------------------
// nttoi_back
// Runs acc = acc * base + digit over 128 bits and registers the result
// beat on the last character of a literal.
// ----------------------------------------------------------------------------
module nttoi_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  nttoi_pkg::entry_t       head,
    input  nttoi_pkg::fifo_status_t q_status,
    output logic                    pop,
    output logic                    res_valid,
    input  logic                    res_stall,
    output logic [63:0]             low_half,
    output logic [63:0]             high_half,
    output logic                    valid_res
);
    import nttoi_pkg::*;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              bad_reg, bad_next;
    logic              res_valid_reg, res_valid_next;
    logic [HALF_W-1:0] low_reg, low_next;
    logic [HALF_W-1:0] high_reg, high_next;
    logic              ok_reg, ok_next;

    logic [ACC_W-1:0]  scaled;
    logic [ACC_W-1:0]  stepped;
    logic              lit_bad;
    logic              out_free;

    // result register can take a new beat when empty or draining
    assign out_free = !res_valid_reg || !res_stall;
    assign pop      = !q_status.empty && (!head.last || out_free);

    // multiply by the base with shifts, then add the digit
    always_comb
    begin
        case (head.radix)
            RADIX_2:  scaled = acc_reg << 1;
            RADIX_8:  scaled = acc_reg << 3;
            RADIX_16: scaled = acc_reg << 4;
            RADIX_10: scaled = (acc_reg << 3) + (acc_reg << 1);
            default:  scaled = acc_reg;
        endcase
        stepped = scaled + {{(ACC_W-4){1'b0}}, head.digit};
    end

    assign lit_bad = bad_reg || head.bad;

    // accumulator and sticky error flag
    always_comb
    begin
        acc_next = acc_reg;
        bad_next = bad_reg;
        if (pop)
        begin
            if (head.last)
            begin
                acc_next = '0;
                bad_next = 1'b0;
            end
            else
            begin
                bad_next = lit_bad;
                if (!head.bad)
                begin
                    acc_next = stepped;
                end
            end
        end
    end

    // result beat register
    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        low_next       = low_reg;
        high_next      = high_reg;
        ok_next        = ok_reg;
        if (pop && head.last)
        begin
            res_valid_next = 1'b1;
            ok_next        = !lit_bad;
            low_next       = lit_bad ? '0 : stepped[HALF_W-1:0];
            high_next      = lit_bad ? '0 : stepped[ACC_W-1:HALF_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            bad_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            bad_reg       <= bad_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg  <= low_next;
        high_reg <= high_next;
        ok_reg   <= ok_next;
    end

    assign res_valid = res_valid_reg;
    assign low_half  = low_reg;
    assign high_half = high_reg;
    assign valid_res = ok_reg;

endmodule

### bench/numeral_text_to_int128_test.sv
// ----------------------------------------------------------------------------
// numeral_text_to_int128_test
// Self-checking bench for the numeral text parser. A short table of literals
// covers the prefix letters, single characters, bad bytes and a prefix letter
// that closes its literal. Random literals in every base follow, some long
// enough to wrap the 128-bit value, some corrupted and some pure noise, under
// several sender idle and receiver stall mixes and one long receiver hold.
// Each result beat is checked against a bit-true parser model kept here.
// ----------------------------------------------------------------------------
module numeral_text_to_int128_test;

    timeunit 1ns;
    timeprecision 1ps;

    import nttoi_pkg::*;

    // one parsed literal as the result channel shows it
    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        ok;
    } numeral_value_t;

    // one directed character, with its result typed in where it is obvious
    typedef struct packed {
        logic [7:0]     code;
        logic           fin;
        logic           typed;
        numeral_value_t val;
    } dir_row_t;

    localparam logic [7:0] CH_NINE = "9";
    localparam logic [7:0] CH_A_LO = "a";
    localparam logic [7:0] CH_F_LO = "f";
    localparam logic [7:0] CH_A_UP = "A";
    localparam logic [7:0] CH_F_UP = "F";
    localparam logic [4:0] NOT_DIGIT = 5'h1F;
    localparam int DIR_ROWS = 24;
    localparam int PHASE_CHARS = 250;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        char_valid;
    logic        char_stall;
    logic [7:0]  char_code;
    logic        is_last;
    logic        res_valid;
    logic        res_stall;
    logic [63:0] low_half;
    logic [63:0] high_half;
    logic        valid_res;

    // parser model state
    logic [127:0] pr_acc;
    radix_t       pr_base;
    logic [1:0]   pr_pos;
    logic         pr_lead_zero;
    logic         pr_bad;

    numeral_value_t expected_values[$];
    dir_row_t       dir_rows[DIR_ROWS];
    int unsigned    sender_gap_pct;
    int unsigned    recv_stall_pct;
    int             hold_request;
    int             fail_count;
    int             idle_cycles;

    numeral_text_to_int128 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_code  (char_code),
        .is_last    (is_last),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .low_half   (low_half),
        .high_half  (high_half),
        .valid_res  (valid_res)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // value of a digit character, NOT_DIGIT for anything else
    function automatic logic [4:0] digit_of(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return 5'(c - CH_ZERO);
        if (c >= CH_A_LO && c <= CH_F_LO)
            return 5'(c - CH_A_LO + 8'd10);
        if (c >= CH_A_UP && c <= CH_F_UP)
            return 5'(c - CH_A_UP + 8'd10);
        return NOT_DIGIT;
    endfunction

    // advance the parser model by one character; done marks a finished literal
    task automatic parse_char(input logic [7:0] c, input logic fin,
                              output logic done, output numeral_value_t v);
        logic       prefix;
        logic [4:0] d;
        logic [4:0] base_n;
        prefix = 1'b0;
        v = '0;
        // prefix letter only counts right after a leading zero, with more to come
        if (pr_pos == 2'd1 && pr_lead_zero && !fin)
        begin
            case (c)
                CH_X_LO, CH_X_UP: begin pr_base = RADIX_16; prefix = 1'b1; end
                CH_B_LO, CH_B_UP: begin pr_base = RADIX_2;  prefix = 1'b1; end
                CH_O_LO, CH_O_UP: begin pr_base = RADIX_8;  prefix = 1'b1; end
                default: ;
            endcase
        end
        case (pr_base)
            RADIX_2:  base_n = 5'd2;
            RADIX_8:  base_n = 5'd8;
            RADIX_16: base_n = 5'd16;
            default:  base_n = 5'd10;
        endcase
        // digit check and wrapping multiply-add
        if (!prefix)
        begin
            d = digit_of(c);
            if (d == NOT_DIGIT || d >= base_n)
                pr_bad = 1'b1;
            else
                pr_acc = pr_acc * 128'(base_n) + 128'(d);
        end
        if (pr_pos == 2'd0)
            pr_lead_zero = (c == CH_ZERO);
        if (pr_pos < 2'd2)
            pr_pos = pr_pos + 2'd1;
        done = fin;
        if (fin)
        begin
            if (!pr_bad)
                v = '{pr_acc[63:0], pr_acc[127:64], 1'b1};
            pr_acc = '0;
            pr_base = RADIX_10;
            pr_pos = 2'd0;
            pr_lead_zero = 1'b0;
            pr_bad = 1'b0;
        end
    endtask

    // offer one character beat, wait for it to be taken, then predict
    task automatic send_beat(input logic [7:0] c, input logic fin,
                             input logic typed, input numeral_value_t typed_val);
        logic           done;
        numeral_value_t v;
        if ($urandom_range(99) < sender_gap_pct)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_code  <= c;
        is_last    <= fin;
        do
            @(posedge clk);
        while (char_stall);
        parse_char(c, fin, done, v);
        if (done)
            expected_values.push_back(typed ? typed_val : v);
    endtask

    // stimulus
    initial
    begin
        logic [7:0]  lit_q[$];
        int unsigned pick;
        int unsigned base_n;
        int unsigned n_digits;
        int unsigned long_lo;
        int unsigned long_hi;
        int unsigned d;
        int          phase_chars;
        logic        fill_max;
        logic [7:0]  pfx;
        radix_t      gen_base;

        rst_n = 1'b0;
        char_valid = 1'b0;
        char_code = '0;
        is_last = 1'b0;
        sender_gap_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        fail_count = 0;
        pr_acc = '0;
        pr_base = RADIX_10;
        pr_pos = 2'd0;
        pr_lead_zero = 1'b0;
        pr_bad = 1'b0;

        // single characters, bad bytes, every prefix letter, prefix at the end
        dir_rows = '{
            '{CH_ZERO, 1'b1, 1'b1, '{64'd0, 64'd0, 1'b1}},
            '{CH_NINE, 1'b1, 1'b1, '{64'd9, 64'd0, 1'b1}},
            '{8'h00,   1'b1, 1'b1, '{64'd0, 64'd0, 1'b0}},
            '{8'hFF,   1'b1, 1'b1, '{64'd0, 64'd0, 1'b0}},
            '{CH_ZERO, 1'b0, 1'b0, '0},
            '{CH_X_UP, 1'b1, 1'b1, '{64'd0, 64'd0, 1'b0}},
            '{CH_ZERO, 1'b0, 1'b0, '0},
            '{CH_B_LO, 1'b0, 1'b0, '0},
            '{"1",     1'b1, 1'b0, '0},
            '{CH_ZERO, 1'b0, 1'b0, '0},
            '{CH_O_UP, 1'b0, 1'b0, '0},
            '{"7",     1'b1, 1'b0, '0},
            '{CH_ZERO, 1'b0, 1'b0, '0},
            '{CH_X_LO, 1'b0, 1'b0, '0},
            '{CH_F_UP, 1'b0, 1'b0, '0},
            '{CH_A_LO, 1'b1, 1'b0, '0},
            '{CH_ZERO, 1'b0, 1'b0, '0},
            '{"1",     1'b0, 1'b0, '0},
            '{"2",     1'b1, 1'b0, '0},
            '{CH_ZERO, 1'b0, 1'b0, '0},
            '{CH_B_UP, 1'b0, 1'b0, '0},
            '{"2",     1'b1, 1'b1, '{64'd0, 64'd0, 1'b0}},
            '{CH_ZERO, 1'b0, 1'b0, '0},
            '{CH_O_LO, 1'b1, 1'b1, '{64'd0, 64'd0, 1'b0}}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed literals
        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(dir_rows[i].code, dir_rows[i].fin, dir_rows[i].typed,
                      dir_rows[i].val);

        // random literals, one idle and stall mix per phase
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin sender_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_gap_pct = 45; recv_stall_pct = 0;  end
                2: begin sender_gap_pct = 0;  recv_stall_pct = 45; end
                default: begin sender_gap_pct = 14; recv_stall_pct = 14; end
            endcase
            // long receiver hold so the block fills and stalls its input
            if (phase == 0)
                hold_request = HOLD_CYCLES;
            phase_chars = 0;
            while (phase_chars < PHASE_CHARS)
            begin
                lit_q.delete();
                pick = $urandom_range(99);
                if (pick < 80)
                begin
                    // well-formed literal, optionally prefixed
                    gen_base = radix_t'($urandom_range(3));
                    pfx = CH_ZERO;
                    case (gen_base)
                        RADIX_2:
                        begin
                            base_n = 2; long_lo = 60; long_hi = 130;
                            pfx = $urandom_range(1) ? CH_B_LO : CH_B_UP;
                        end
                        RADIX_8:
                        begin
                            base_n = 8; long_lo = 20; long_hi = 46;
                            pfx = $urandom_range(1) ? CH_O_LO : CH_O_UP;
                        end
                        RADIX_16:
                        begin
                            base_n = 16; long_lo = 15; long_hi = 34;
                            pfx = $urandom_range(1) ? CH_X_LO : CH_X_UP;
                        end
                        default:
                        begin
                            base_n = 10; long_lo = 18; long_hi = 42;
                        end
                    endcase
                    if (gen_base != RADIX_10)
                    begin
                        lit_q.push_back(CH_ZERO);
                        lit_q.push_back(pfx);
                    end
                    n_digits = ($urandom_range(7) == 0) ?
                               $urandom_range(long_hi, long_lo) : $urandom_range(6, 1);
                    fill_max = ($urandom_range(7) == 0);
                    repeat (n_digits)
                    begin
                        d = fill_max ? base_n - 1 : $urandom_range(base_n - 1);
                        if (d < 10)
                            lit_q.push_back(8'(CH_ZERO + d));
                        else
                            lit_q.push_back(8'(($urandom_range(1) ? CH_A_LO : CH_A_UP)
                                               + d - 10));
                    end
                    // some well-formed literals get one byte corrupted
                    if (pick >= 70)
                        lit_q[$urandom_range(lit_q.size() - 1)] = 8'($urandom_range(255));
                end
                else if (pick < 88)
                begin
                    // prefix letter as the last character, or one random byte
                    if ($urandom_range(1))
                    begin
                        lit_q.push_back(CH_ZERO);
                        case ($urandom_range(5))
                            0: lit_q.push_back(CH_X_LO);
                            1: lit_q.push_back(CH_X_UP);
                            2: lit_q.push_back(CH_B_LO);
                            3: lit_q.push_back(CH_B_UP);
                            4: lit_q.push_back(CH_O_LO);
                            default: lit_q.push_back(CH_O_UP);
                        endcase
                    end
                    else
                        lit_q.push_back(8'($urandom_range(255)));
                end
                else
                begin
                    // noise bytes
                    repeat ($urandom_range(8, 1))
                        lit_q.push_back(8'($urandom_range(255)));
                end
                foreach (lit_q[i])
                    send_beat(lit_q[i], i == lit_q.size() - 1, 1'b0, '0);
                phase_chars += lit_q.size();
            end
        end
        char_valid <= 1'b0;

        // drain, then give stray beats a chance to show up
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // result receiver: random stalls, plus the long hold when asked
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            else
                res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        numeral_value_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_values.size() == 0)
            begin
                if (fail_count < 10)
                    $display("unexpected result beat: lo=%h hi=%h ok=%b",
                             low_half, high_half, valid_res);
                fail_count++;
            end
            else
            begin
                want = expected_values.pop_front();
                if (low_half !== want.lo || high_half !== want.hi ||
                    valid_res !== want.ok)
                begin
                    if (fail_count < 10)
                        $display("result mismatch: expected lo=%h hi=%h ok=%b, got lo=%h hi=%h ok=%b",
                                 want.lo, want.hi, want.ok, low_half, high_half, valid_res);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: too long without any beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (char_valid && !char_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_values.size());
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
